// File: rtl/core/usm_pkg.sv
// Shared types, constants and the arctangent table of the UV sphere generator.
// Used by usm_div, usm_cordic and the top level; depends on nothing.
package usm_pkg;

  // Register limits and reset values
  localparam logic [6:0]  SectorMin    = 7'd3;
  localparam logic [6:0]  SectorMax    = 7'd64;
  localparam logic [6:0]  StackMin     = 7'd2;
  localparam logic [6:0]  StackMax     = 7'd64;
  localparam logic [6:0]  SectorReset  = 7'd36;
  localparam logic [6:0]  StackReset   = 7'd18;
  localparam logic [15:0] RadiusReset  = 16'd256;

  // Register indexes on the configuration port
  typedef enum logic [1:0] {
    REG_SECTORS = 2'd0,
    REG_STACKS  = 2'd1,
    REG_RADIUS  = 2'd2,
    REG_NONE    = 2'd3
  } reg_idx_e;

  // Pipeline shape
  localparam int DivStages    = 8;   // two quotient bits per stage
  localparam int CordicIters  = 28;
  localparam int CordicStages = CordicIters / 2;
  localparam int CordicLat    = CordicStages + 1;
  localparam int MathLat      = 3;
  localparam int PipeDepth    = 1 + DivStages + CordicLat + MathLat;
  localparam int TexStage     = 1 + DivStages;

  localparam logic signed [31:0] CordicGain = 32'sd652032874;

  // Rotation state of one CORDIC lane
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } cordic_t;

  // Item info that rides alongside the math pipeline
  typedef struct packed {
    logic        valid;
    logic        mode;
    logic        has_left;
    logic        has_right;
    logic [12:0] k1;
    logic [12:0] k2;
    logic [15:0] tex_u;
    logic [15:0] tex_v;
  } side_t;

  // Arctangent of 2^-k in 2^-32 turn units
  function automatic logic signed [31:0] atan_turn(input int k);
    logic signed [31:0] v;
    unique case (k)
      0:  v = 32'sd536870912;
      1:  v = 32'sd316933406;
      2:  v = 32'sd167458907;
      3:  v = 32'sd85004756;
      4:  v = 32'sd42667331;
      5:  v = 32'sd21354465;
      6:  v = 32'sd10679838;
      7:  v = 32'sd5340245;
      8:  v = 32'sd2670163;
      9:  v = 32'sd1335087;
      10: v = 32'sd667544;
      11: v = 32'sd333772;
      12: v = 32'sd166886;
      13: v = 32'sd83443;
      14: v = 32'sd41722;
      15: v = 32'sd20861;
      16: v = 32'sd10430;
      17: v = 32'sd5215;
      18: v = 32'sd2608;
      19: v = 32'sd1304;
      20: v = 32'sd652;
      21: v = 32'sd326;
      22: v = 32'sd163;
      23: v = 32'sd81;
      24: v = 32'sd41;
      25: v = 32'sd20;
      26: v = 32'sd10;
      27: v = 32'sd5;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/core/usm_div.sv
// Pipelined restoring divider, 16 quotient bits, two bits per stage.
// Depends on usm_pkg for the stage count.
module usm_div (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [22:0] num_i,
  input  logic [7:0]  den_i,
  output logic [15:0] quo_o
);

  logic [22:0] rem_q [usm_pkg::DivStages];
  logic [15:0] quo_q [usm_pkg::DivStages];
  logic [7:0]  den_q [usm_pkg::DivStages];
  logic [22:0] rem_d [usm_pkg::DivStages];
  logic [15:0] quo_d [usm_pkg::DivStages];
  logic [7:0]  den_d [usm_pkg::DivStages];

  // Resolve two quotient bits per stage, top bit first
  always_comb begin
    logic [22:0] r;
    logic [15:0] q;
    logic [7:0]  d;
    logic [22:0] sub;
    for (int s = 0; s < usm_pkg::DivStages; s++) begin
      if (s == 0) begin
        r = num_i;
        q = '0;
        d = den_i;
      end else begin
        r = rem_q[s-1];
        q = quo_q[s-1];
        d = den_q[s-1];
      end
      for (int b = 1; b >= 0; b--) begin
        sub = 23'(d) << (15 - 2 * s - 1 + b);
        if (r >= sub) begin
          r = r - sub;
          q[15 - 2 * s - 1 + b] = 1'b1;
        end
      end
      rem_d[s] = r;
      quo_d[s] = q;
      den_d[s] = d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < usm_pkg::DivStages; s++) begin
        rem_q[s] <= rem_d[s];
        quo_q[s] <= quo_d[s];
        den_q[s] <= den_d[s];
      end
    end
  end

  assign quo_o = quo_q[usm_pkg::DivStages-1];

endmodule

// File: rtl/core/usm_cordic.sv
// Pipelined CORDIC: cos and sin in Q1.14 of a 12 bit angle code.
// Two iterations per stage, then rounding and quadrant fold; uses usm_pkg.
module usm_cordic (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [11:0]        code_i,
  output logic signed [15:0] cos_o,
  output logic signed [15:0] sin_o
);

  usm_pkg::cordic_t st_q [usm_pkg::CordicStages];
  usm_pkg::cordic_t st_d [usm_pkg::CordicStages];
  logic [1:0]       quad_q [usm_pkg::CordicStages];
  logic signed [15:0] cos_q, sin_q;
  logic signed [15:0] cq, sq;

  function automatic usm_pkg::cordic_t rotate(input usm_pkg::cordic_t a, input int k);
    usm_pkg::cordic_t r;
    logic signed [31:0] dx, dy;
    dx = a.y >>> k;
    dy = a.x >>> k;
    r  = a;
    if (a.z >= 0) begin
      r.x = a.x - dx;
      r.y = a.y + dy;
      r.z = a.z - usm_pkg::atan_turn(k);
    end else begin
      r.x = a.x + dx;
      r.y = a.y - dy;
      r.z = a.z + usm_pkg::atan_turn(k);
    end
    return r;
  endfunction

  // Round half up to Q1.14 and clamp to plus or minus one
  function automatic logic signed [15:0] to_q14(input logic signed [31:0] v);
    logic signed [32:0] r;
    r = (33'(v) + 33'sd32768) >>> 16;
    if (r > 33'sd16384) r = 33'sd16384;
    if (r < -33'sd16384) r = -33'sd16384;
    return r[15:0];
  endfunction

  // Advance two micro-rotations per stage
  always_comb begin
    usm_pkg::cordic_t cur;
    for (int s = 0; s < usm_pkg::CordicStages; s++) begin
      if (s == 0) begin
        cur.x = usm_pkg::CordicGain;
        cur.y = '0;
        cur.z = $signed({2'b00, code_i[9:0], 20'd0});
      end else begin
        cur = st_q[s-1];
      end
      cur = rotate(cur, 2 * s);
      cur = rotate(cur, 2 * s + 1);
      st_d[s] = cur;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < usm_pkg::CordicStages; s++) begin
        st_q[s]   <= st_d[s];
        quad_q[s] <= (s == 0) ? code_i[11:10] : quad_q[s-1];
      end
    end
  end

  // Fold the first-quadrant result into the angle's quadrant
  assign cq = to_q14(st_q[usm_pkg::CordicStages-1].x);
  assign sq = to_q14(st_q[usm_pkg::CordicStages-1].y);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      unique case (quad_q[usm_pkg::CordicStages-1])
        2'd0: begin cos_q <= cq;  sin_q <= sq;  end
        2'd1: begin cos_q <= -sq; sin_q <= cq;  end
        2'd2: begin cos_q <= -cq; sin_q <= -sq; end
        default: begin cos_q <= sq; sin_q <= -cq; end
      endcase
    end
  end

  assign cos_o = cos_q;
  assign sin_o = sin_q;

endmodule

// File: rtl/core/usm_vmath.sv
// Vertex arithmetic: normals and radius-scaled positions from cos/sin.
// Three register stages, multipliers in the first two; uses no package items.
module usm_vmath (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [15:0] cp_i,
  input  logic signed [15:0] sp_i,
  input  logic signed [15:0] ct_i,
  input  logic signed [15:0] st_i,
  input  logic [15:0]        radius_i,
  output logic signed [16:0] pos_x_o,
  output logic signed [16:0] pos_y_o,
  output logic signed [16:0] pos_z_o,
  output logic signed [15:0] norm_x_o,
  output logic signed [15:0] norm_y_o,
  output logic signed [15:0] norm_z_o
);

  logic signed [16:0] rad;
  logic signed [31:0] pcct_q, pcst_q;
  logic signed [32:0] rsp_q;
  logic signed [15:0] sp1_q, nx_q, ny_q, nz_q, nx2_q, ny2_q, nz2_q;
  logic signed [47:0] px_q, py_q;
  logic signed [16:0] pz_q, pz2_q;
  logic signed [47:0] px_r, py_r;
  logic signed [31:0] nx_r, ny_r;
  logic signed [32:0] pz_r;

  assign rad = $signed({1'b0, radius_i});

  // Round the products half up
  assign nx_r = (pcct_q + 32'sd8192) >>> 14;
  assign ny_r = (pcst_q + 32'sd8192) >>> 14;
  assign pz_r = (rsp_q + 33'sd8192) >>> 14;
  assign px_r = (px_q + 48'sd134217728) >>> 28;
  assign py_r = (py_q + 48'sd134217728) >>> 28;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // first products
      pcct_q <= 32'(cp_i) * 32'(ct_i);
      pcst_q <= 32'(cp_i) * 32'(st_i);
      rsp_q  <= 33'(rad) * 33'(sp_i);
      sp1_q  <= sp_i;
      // scale by radius, finish normals
      px_q   <= 48'(rad) * 48'(pcct_q);
      py_q   <= 48'(rad) * 48'(pcst_q);
      pz_q   <= pz_r[16:0];
      nx_q   <= nx_r[15:0];
      ny_q   <= ny_r[15:0];
      nz_q   <= sp1_q;
      // final rounding of x and y
      pos_x_o  <= px_r[16:0];
      pos_y_o  <= py_r[16:0];
      pz2_q    <= pz_q;
      nx2_q    <= nx_q;
      ny2_q    <= ny_q;
      nz2_q    <= nz_q;
    end
  end

  assign pos_z_o  = pz2_q;
  assign norm_x_o = nx2_q;
  assign norm_y_o = ny2_q;
  assign norm_z_o = nz2_q;

endmodule

// File: rtl/core/uv_sphere_mesh_generator_unit.sv
// Top level of the UV sphere mesh generator: register port, pipeline, output.
// Instantiates usm_div, usm_cordic and usm_vmath; uses usm_pkg.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  config  | psel penable pwrite paddr pwdata prdata   | APB slave
//  request | in_valid_i in_ready_o mode/stack/sector   | in
//  result  | out_valid_o out_ready_i pos/norm/tex/corner| out
//
// An item enters every cycle while in_ready_o is high; results pass the entry,
// divider, CORDIC and multiplier stages plus the output register.
// A cell with two triangles stalls the pipeline until its second triangle is taken.
// The whole pipeline advances together; a stalled output freezes it.
// Reset clears valid bits and sets the registers to 36, 18 and 1.0.
module uv_sphere_mesh_generator_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               mode_i,
  input  logic [6:0]         stack_index_i,
  input  logic [6:0]         sector_index_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [16:0] pos_x_o,
  output logic signed [16:0] pos_y_o,
  output logic signed [16:0] pos_z_o,
  output logic signed [15:0] norm_x_o,
  output logic signed [15:0] norm_y_o,
  output logic signed [15:0] norm_z_o,
  output logic [15:0]        tex_u_o,
  output logic [15:0]        tex_v_o,
  output logic [12:0]        corner_a_o,
  output logic [12:0]        corner_b_o,
  output logic [12:0]        corner_c_o,
  output logic               last_o
);

  logic [6:0]  sectors_q, stacks_q;
  logic [15:0] radius_q;
  usm_pkg::reg_idx_e ridx;
  logic        adv;

  // Configuration registers
  assign pready = 1'b1;
  assign ridx   = usm_pkg::reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sectors_q <= usm_pkg::SectorReset;
      stacks_q  <= usm_pkg::StackReset;
      radius_q  <= usm_pkg::RadiusReset;
    end else if (psel && penable && pwrite) begin
      unique case (ridx)
        usm_pkg::REG_SECTORS: sectors_q <= pwdata[6:0];
        usm_pkg::REG_STACKS:  stacks_q  <= pwdata[6:0];
        usm_pkg::REG_RADIUS:  radius_q  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      usm_pkg::REG_SECTORS: prdata = {25'd0, sectors_q};
      usm_pkg::REG_STACKS:  prdata = {25'd0, stacks_q};
      usm_pkg::REG_RADIUS:  prdata = {16'd0, radius_q};
      default:              prdata = '0;
    endcase
  end

  // Entry: clamp counts, check range, form numerators and cell indices
  logic [6:0]  s_eff, t_eff;
  logic        ok;
  logic [13:0] k1w, k2w;
  usm_pkg::side_t entry;

  always_comb begin
    s_eff = sectors_q;
    if (sectors_q < usm_pkg::SectorMin) s_eff = usm_pkg::SectorMin;
    if (sectors_q > usm_pkg::SectorMax) s_eff = usm_pkg::SectorMax;
    t_eff = stacks_q;
    if (stacks_q < usm_pkg::StackMin) t_eff = usm_pkg::StackMin;
    if (stacks_q > usm_pkg::StackMax) t_eff = usm_pkg::StackMax;
    if (mode_i) ok = (stack_index_i < t_eff) && (sector_index_i < s_eff);
    else        ok = (stack_index_i <= t_eff) && (sector_index_i <= s_eff);
    k1w = 14'(stack_index_i) * (14'(s_eff) + 14'd1) + 14'(sector_index_i);
    k2w = k1w + 14'(s_eff) + 14'd1;
    entry.valid     = in_valid_i && ok;
    entry.mode      = mode_i;
    entry.has_left  = (stack_index_i != 7'd0);
    entry.has_right = (stack_index_i != t_eff - 7'd1);
    entry.k1        = k1w[12:0];
    entry.k2        = k2w[12:0];
    entry.tex_u     = '0;
    entry.tex_v     = '0;
  end

  logic [22:0] n_pc_q, n_tc_q, n_u_q, n_v_q;
  logic [7:0]  d_s_q, d_t_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      n_pc_q <= 23'({stack_index_i, 12'd0}) + 23'(t_eff);
      n_tc_q <= 23'({sector_index_i, 13'd0}) + 23'(s_eff);
      n_u_q  <= {sector_index_i, 16'd0} + 23'(s_eff);
      n_v_q  <= {stack_index_i, 16'd0} + 23'(t_eff);
      d_s_q  <= {s_eff, 1'b0};
      d_t_q  <= {t_eff, 1'b0};
    end
  end

  // Angle and texture ratios
  logic [15:0] q_pc, q_tc, q_u, q_v;

  usm_div u_div_pc (.clk_i, .en_i(adv), .num_i(n_pc_q), .den_i(d_t_q), .quo_o(q_pc));
  usm_div u_div_tc (.clk_i, .en_i(adv), .num_i(n_tc_q), .den_i(d_s_q), .quo_o(q_tc));
  usm_div u_div_u  (.clk_i, .en_i(adv), .num_i(n_u_q),  .den_i(d_s_q), .quo_o(q_u));
  usm_div u_div_v  (.clk_i, .en_i(adv), .num_i(n_v_q),  .den_i(d_t_q), .quo_o(q_v));

  // Latitude starts at a quarter turn and goes down
  logic [11:0] phi_code, theta_code;
  assign phi_code   = 12'd1024 - q_pc[11:0];
  assign theta_code = q_tc[11:0];

  logic signed [15:0] cp, sp, ct, st;

  usm_cordic u_cordic_phi   (.clk_i, .en_i(adv), .code_i(phi_code),   .cos_o(cp), .sin_o(sp));
  usm_cordic u_cordic_theta (.clk_i, .en_i(adv), .code_i(theta_code), .cos_o(ct), .sin_o(st));

  logic signed [16:0] px, py, pz;
  logic signed [15:0] nx, ny, nz;

  usm_vmath u_vmath (
    .clk_i, .en_i(adv), .cp_i(cp), .sp_i(sp), .ct_i(ct), .st_i(st),
    .radius_i(radius_q), .pos_x_o(px), .pos_y_o(py), .pos_z_o(pz),
    .norm_x_o(nx), .norm_y_o(ny), .norm_z_o(nz)
  );

  // Side line: valid bits and cell info travel with the math
  usm_pkg::side_t side_q [usm_pkg::PipeDepth];
  usm_pkg::side_t tex_side;

  // Attach the texture ratios where the dividers finish
  always_comb begin
    tex_side       = side_q[usm_pkg::TexStage-1];
    tex_side.tex_u = q_u;
    tex_side.tex_v = q_v;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < usm_pkg::PipeDepth; s++) side_q[s] <= '0;
    end else if (adv) begin
      side_q[0] <= entry;
      for (int s = 1; s < usm_pkg::PipeDepth; s++) begin
        if (s == usm_pkg::TexStage) side_q[s] <= tex_side;
        else                        side_q[s] <= side_q[s-1];
      end
    end
  end

  // Output word register with a held second triangle
  usm_pkg::side_t tail;
  logic        out_valid_q, pend_q;
  logic [12:0] pend_a_q, pend_b_q, pend_c_q;

  assign tail       = side_q[usm_pkg::PipeDepth-1];
  assign adv        = !out_valid_q || (out_ready_i && !pend_q);
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else if (adv) begin
      out_valid_q <= tail.valid;
      pend_q      <= tail.valid && tail.mode && tail.has_left && tail.has_right;
    end else if (out_ready_i && pend_q) begin
      pend_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pend_a_q <= tail.k1 + 13'd1;
      pend_b_q <= tail.k2;
      pend_c_q <= tail.k2 + 13'd1;
      if (tail.mode) begin
        pos_x_o  <= '0;
        pos_y_o  <= '0;
        pos_z_o  <= '0;
        norm_x_o <= '0;
        norm_y_o <= '0;
        norm_z_o <= '0;
        tex_u_o  <= '0;
        tex_v_o  <= '0;
        last_o   <= !(tail.has_left && tail.has_right);
        if (tail.has_left) begin
          corner_a_o <= tail.k1;
          corner_b_o <= tail.k2;
          corner_c_o <= tail.k1 + 13'd1;
        end else begin
          corner_a_o <= tail.k1 + 13'd1;
          corner_b_o <= tail.k2;
          corner_c_o <= tail.k2 + 13'd1;
        end
      end else begin
        pos_x_o    <= px;
        pos_y_o    <= py;
        pos_z_o    <= pz;
        norm_x_o   <= nx;
        norm_y_o   <= ny;
        norm_z_o   <= nz;
        tex_u_o    <= tail.tex_u;
        tex_v_o    <= tail.tex_v;
        corner_a_o <= '0;
        corner_b_o <= '0;
        corner_c_o <= '0;
        last_o     <= 1'b1;
      end
    end else if (out_ready_i && pend_q) begin
      corner_a_o <= pend_a_q;
      corner_b_o <= pend_b_q;
      corner_c_o <= pend_c_q;
      last_o     <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;

  // A held second triangle only exists behind a shown word
  a_pend_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> out_valid_q) else $error("second triangle without word");

  // A blocked output word freezes the intake
  a_stall_intake: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !in_ready_o) else $error("intake during stall");

  // A word that is not last is the first triangle of a cell
  a_first_is_cell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_o) |-> (tex_u_o == 16'd0 && tex_v_o == 16'd0 && pend_q))
    else $error("non-final word is not a cell triangle");

endmodule
